// ===== rtl/core/asp_pkg.sv =====
// Shared types and reset values for the ANSI SGR stream parser.
`timescale 1ns / 1ps

package asp_pkg;

    // Color index: 0 black .. 7 white
    typedef logic [2:0] color_t;

    // Font weight: 0 light, 1 normal, 2 medium, 3 bold
    typedef logic [1:0] weight_t;

    // Text attributes carried with every plain word
    typedef struct packed {
        color_t  fg;
        color_t  bg;
        weight_t weight;
        logic    italic;
        logic    underline;
        logic    overline;
        logic    strike;
    } attr_t;

    localparam color_t  COLOR_BLACK   = 3'd0;
    localparam color_t  COLOR_WHITE   = 3'd7;
    localparam weight_t WEIGHT_LIGHT  = 2'd0;
    localparam weight_t WEIGHT_NORMAL = 2'd1;
    localparam weight_t WEIGHT_MEDIUM = 2'd2;
    localparam weight_t WEIGHT_BOLD   = 2'd3;

    localparam attr_t ATTR_RESET = '{
        fg:        COLOR_BLACK,
        bg:        COLOR_WHITE,
        weight:    WEIGHT_MEDIUM,
        italic:    1'b0,
        underline: 1'b0,
        overline:  1'b0,
        strike:    1'b0
    };

endpackage

// ===== rtl/core/asp_sgr_apply.sv =====
// SGR code decoder: applies one select-graphic-rendition code to the attributes.
`timescale 1ns / 1ps

module asp_sgr_apply
(
    input  logic          apply_en,
    input  logic [7:0]    code,
    input  asp_pkg::attr_t attr_in,
    output asp_pkg::attr_t attr_out
);

    localparam logic [7:0] SGR_RESET        = 8'd0;
    localparam logic [7:0] SGR_BOLD         = 8'd1;
    localparam logic [7:0] SGR_LIGHT        = 8'd2;
    localparam logic [7:0] SGR_ITALIC       = 8'd3;
    localparam logic [7:0] SGR_UNDERLINE    = 8'd4;
    localparam logic [7:0] SGR_SWAP         = 8'd7;
    localparam logic [7:0] SGR_STRIKE       = 8'd9;
    localparam logic [7:0] SGR_NORMAL       = 8'd21;
    localparam logic [7:0] SGR_COLORS_DFLT  = 8'd22;
    localparam logic [7:0] SGR_ITALIC_OFF   = 8'd23;
    localparam logic [7:0] SGR_UNDERLN_OFF  = 8'd24;
    localparam logic [7:0] SGR_SWAP_ALT     = 8'd27;
    localparam logic [7:0] SGR_STRIKE_OFF   = 8'd29;
    localparam logic [7:0] SGR_FG_FIRST     = 8'd30;
    localparam logic [7:0] SGR_FG_LAST      = 8'd37;
    localparam logic [7:0] SGR_FG_DFLT      = 8'd39;
    localparam logic [7:0] SGR_BG_FIRST     = 8'd40;
    localparam logic [7:0] SGR_BG_LAST      = 8'd47;
    localparam logic [7:0] SGR_BG_DFLT      = 8'd49;
    localparam logic [7:0] SGR_OVERLINE     = 8'd53;
    localparam logic [7:0] SGR_OVERLN_OFF   = 8'd55;

    logic [7:0] fg_offset;
    logic [7:0] bg_offset;

    assign fg_offset = code - SGR_FG_FIRST;
    assign bg_offset = code - SGR_BG_FIRST;

    // Decode the code and update the selected attribute
    always_comb
    begin
        attr_out = attr_in;
        if (apply_en)
        begin
            case (code)
                SGR_RESET:       attr_out = asp_pkg::ATTR_RESET;
                SGR_BOLD:        attr_out.weight = asp_pkg::WEIGHT_BOLD;
                SGR_LIGHT:       attr_out.weight = asp_pkg::WEIGHT_LIGHT;
                SGR_ITALIC:      attr_out.italic = 1'b1;
                SGR_UNDERLINE:   attr_out.underline = 1'b1;
                SGR_SWAP,
                SGR_SWAP_ALT:
                begin
                    attr_out.fg = attr_in.bg;
                    attr_out.bg = attr_in.fg;
                end
                SGR_STRIKE:      attr_out.strike = 1'b1;
                SGR_NORMAL:      attr_out.weight = asp_pkg::WEIGHT_NORMAL;
                SGR_COLORS_DFLT:
                begin
                    attr_out.fg = asp_pkg::COLOR_BLACK;
                    attr_out.bg = asp_pkg::COLOR_WHITE;
                end
                SGR_ITALIC_OFF:  attr_out.italic = 1'b0;
                SGR_UNDERLN_OFF: attr_out.underline = 1'b0;
                SGR_STRIKE_OFF:  attr_out.strike = 1'b0;
                SGR_FG_DFLT:     attr_out.fg = asp_pkg::COLOR_BLACK;
                SGR_BG_DFLT:     attr_out.bg = asp_pkg::COLOR_WHITE;
                SGR_OVERLINE:    attr_out.overline = 1'b1;
                SGR_OVERLN_OFF:  attr_out.overline = 1'b0;
                default:
                begin
                    // Color ranges; everything else is ignored
                    if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST)
                    begin
                        attr_out.fg = fg_offset[2:0];
                    end
                    else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST)
                    begin
                        attr_out.bg = bg_offset[2:0];
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ansi_sgr_stream_parser_core.sv =====
// Top level of the ANSI SGR stream parser: byte parsing, attribute state, output register.
`timescale 1ns / 1ps

// Takes one terminal byte per word and returns one word per plain byte, tagged with the
// text attributes in force at that byte; ESC and control-sequence bytes give no word.
// Sustained rate is one byte per clock while in_stall is low: a byte sits in an input
// register, the parser and attribute registers are updated from it, and a plain byte lands
// in the output register, which raises out_valid. The rate is set by the loop through the
// parse state and the SGR decoder. A word held in the output register under out_stall
// stalls the input only once the input register is also full and the byte in it would
// produce a word.
module ansi_sgr_stream_parser_core
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       chunk_end,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_char,
    output logic [2:0] fg_color,
    output logic [2:0] bg_color,
    output logic [1:0] weight,
    output logic       italic_on,
    output logic       underline_on,
    output logic       overline_on,
    output logic       strike_on
);

    localparam logic [7:0] BYTE_ESC      = 8'h1B;
    localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SEMI     = 8'h3B;
    localparam logic [7:0] PARAM_MAX     = 8'hFF;
    localparam logic [1:0] FINAL_TAG     = 2'b01;
    localparam logic [3:0] DIGIT_HIGH    = 4'h3;
    localparam logic [3:0] DIGIT_MAX     = 4'd9;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_CSI   = 2'd2
    } mode_t;

    // Input register
    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;

    // Parse and attribute state
    mode_t          mode_reg, mode_next;
    logic [7:0]     accum_reg, accum_next;
    logic           digits_reg, digits_next;
    logic           halted_reg, halted_next;
    asp_pkg::attr_t attr_reg, attr_next;

    // Output register
    logic           out_valid_reg, out_valid_next;
    logic [7:0]     text_reg;
    asp_pkg::attr_t out_attr_reg;

    logic        emit;
    logic        out_free;
    logic        advance;
    logic        is_final;
    logic        is_digit;
    logic [11:0] accum_sum;
    logic [7:0]  accum_sat;
    logic        apply_first;
    logic        apply_tail;
    logic        apply_en;
    logic [7:0]  apply_code;
    mode_t       mode_mid;
    logic [7:0]  accum_mid;
    logic        digits_mid;
    logic        halted_mid;

    // Byte classes inside a control sequence
    assign is_final = (hold_byte_reg[7:6] == FINAL_TAG);
    assign is_digit = (hold_byte_reg[7:4] == DIGIT_HIGH) && (hold_byte_reg[3:0] <= DIGIT_MAX);

    // Decimal accumulate with saturation
    assign accum_sum = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                     + {8'b0, hold_byte_reg[3:0]};
    assign accum_sat = (accum_sum > {4'b0, PARAM_MAX}) ? PARAM_MAX : accum_sum[7:0];

    // Handshake: drain the input register unless it carries a word the output cannot take
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = hold_valid_reg && (!emit || out_free);
    assign in_stall = hold_valid_reg && !advance;

    // Parse one byte
    always_comb
    begin
        mode_mid    = mode_reg;
        accum_mid   = accum_reg;
        digits_mid  = digits_reg;
        halted_mid  = halted_reg;
        apply_first = 1'b0;
        emit        = 1'b0;

        case (mode_reg)
            MODE_CSI:
            begin
                if (is_final)
                begin
                    apply_first = digits_reg && !halted_reg;
                    mode_mid    = MODE_PLAIN;
                    accum_mid   = '0;
                    digits_mid  = 1'b0;
                    halted_mid  = 1'b0;
                end
                else if (!halted_reg)
                begin
                    if (is_digit)
                    begin
                        accum_mid  = accum_sat;
                        digits_mid = 1'b1;
                    end
                    else if (hold_byte_reg == BYTE_SEMI && digits_reg)
                    begin
                        apply_first = 1'b1;
                        accum_mid   = '0;
                        digits_mid  = 1'b0;
                    end
                    else
                    begin
                        // Anything else stops parsing for the rest of the sequence
                        apply_first = digits_reg;
                        halted_mid  = 1'b1;
                        accum_mid   = '0;
                        digits_mid  = 1'b0;
                    end
                end
            end
            MODE_ESC:
            begin
                mode_mid   = (hold_byte_reg == BYTE_LBRACKET) ? MODE_CSI : MODE_PLAIN;
                accum_mid  = '0;
                digits_mid = 1'b0;
                halted_mid = 1'b0;
            end
            default:
            begin
                if (hold_byte_reg == BYTE_ESC)
                begin
                    mode_mid = MODE_ESC;
                end
                else
                begin
                    mode_mid = MODE_PLAIN;
                    emit     = hold_valid_reg;
                end
            end
        endcase

        // Chunk end: flush the pending field and drop back to plain text
        apply_tail  = hold_last_reg && (mode_mid == MODE_CSI) && digits_mid && !halted_mid;
        mode_next   = mode_mid;
        accum_next  = accum_mid;
        digits_next = digits_mid;
        halted_next = halted_mid;
        if (hold_last_reg)
        begin
            mode_next   = MODE_PLAIN;
            accum_next  = '0;
            digits_next = 1'b0;
            halted_next = 1'b0;
        end
    end

    // At most one code is applied per byte
    assign apply_en   = apply_first || apply_tail;
    assign apply_code = apply_first ? accum_reg : accum_mid;

    asp_sgr_apply u_sgr_apply
    (
        .apply_en (apply_en),
        .code     (apply_code),
        .attr_in  (attr_reg),
        .attr_out (attr_next)
    );

    assign out_valid_next = (out_valid_reg && out_stall) || (emit && advance);

    // Hold input word, control state, attributes and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            hold_byte_reg  <= '0;
            hold_last_reg  <= 1'b0;
            mode_reg       <= MODE_PLAIN;
            accum_reg      <= '0;
            digits_reg     <= 1'b0;
            halted_reg     <= 1'b0;
            attr_reg       <= asp_pkg::ATTR_RESET;
            out_valid_reg  <= 1'b0;
            text_reg       <= '0;
            out_attr_reg   <= asp_pkg::ATTR_RESET;
        end
        else
        begin
            if (!in_stall)
            begin
                hold_valid_reg <= in_valid;
            end
            if (!in_stall && in_valid)
            begin
                hold_byte_reg <= in_byte;
                hold_last_reg <= chunk_end;
            end
            if (advance)
            begin
                mode_reg   <= mode_next;
                accum_reg  <= accum_next;
                digits_reg <= digits_next;
                halted_reg <= halted_next;
                attr_reg   <= attr_next;
            end
            out_valid_reg <= out_valid_next;
            if (emit && advance)
            begin
                text_reg     <= hold_byte_reg;
                out_attr_reg <= attr_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign text_char    = text_reg;
    assign fg_color     = out_attr_reg.fg;
    assign bg_color     = out_attr_reg.bg;
    assign weight       = out_attr_reg.weight;
    assign italic_on    = out_attr_reg.italic;
    assign underline_on = out_attr_reg.underline;
    assign overline_on  = out_attr_reg.overline;
    assign strike_on    = out_attr_reg.strike;

endmodule
